### src/jcee_pkg.sv
// shared types, constants and the event decode function of the joystick change-event encoder
package jcee_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int DELTA_W   = 9;
    localparam int VALUE_W   = 16;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] KEYS_RESET = 8'h2f;
    localparam logic [VALUE_W-1:0] AXIS_NEG = 16'h8000;
    localparam logic [VALUE_W-1:0] AXIS_POS = 16'h7fff;

    // bit positions in a joystick byte
    localparam int KEY_UP    = 0;
    localparam int KEY_LEFT  = 1;
    localparam int KEY_DOWN  = 2;
    localparam int KEY_RIGHT = 3;
    localparam int KEY_FIRE  = 5;

    // event slots of one frame, in emission order
    localparam logic [SLOT_W-1:0] SLOT_PZ_A  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_PS_A  = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_PZ_B  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_PS_B  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_KEY_L = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_KEY_R = 4'd10;

    // offsets inside a key group
    localparam logic [2:0] OFF_UP    = 3'd0;
    localparam logic [2:0] OFF_LEFT  = 3'd1;
    localparam logic [2:0] OFF_DOWN  = 3'd2;
    localparam logic [2:0] OFF_RIGHT = 3'd3;
    localparam logic [2:0] OFF_FIRE  = 3'd4;
    localparam logic [2:0] OFF_SYNC  = 3'd5;

    typedef enum logic [1:0] {
        KIND_AXIS   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_SYNC   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CODE_X    = 2'd0,
        CODE_Y    = 2'd1,
        CODE_Z    = 2'd2,
        CODE_FIRE = 2'd3
    } code_t;

    // one classified frame: which events to emit and what they need
    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic signed [DELTA_W-1:0] delta_a;
        logic signed [DELTA_W-1:0] delta_b;
        logic [7:0]                left_keys;
        logic [7:0]                right_keys;
    } desc_t;

    typedef struct packed {
        logic               port;
        kind_t              kind;
        code_t              code;
        logic [VALUE_W-1:0] value;
    } event_t;

    function automatic logic [VALUE_W-1:0] sext_delta(input logic signed [DELTA_W-1:0] d);
        return {{(VALUE_W-DELTA_W){d[DELTA_W-1]}}, d};
    endfunction

    function automatic event_t ev_decode(input logic [SLOT_W-1:0] slot, input desc_t d);
        event_t     ev;
        logic       rport;
        logic [7:0] k;
        logic [2:0] off;
        rport    = (slot >= SLOT_KEY_R);
        k        = rport ? d.right_keys : d.left_keys;
        off      = rport ? 3'(slot - SLOT_KEY_R) : 3'(slot - SLOT_KEY_L);
        ev.port  = 1'b0;
        ev.kind  = KIND_SYNC;
        ev.code  = CODE_X;
        ev.value = '0;
        case (slot)
            SLOT_PZ_A:
            begin
                ev.kind  = KIND_AXIS;
                ev.code  = CODE_Z;
                ev.value = sext_delta(d.delta_a);
            end
            SLOT_PS_A:
            begin
                ev.kind = KIND_SYNC;
            end
            SLOT_PZ_B:
            begin
                ev.port  = 1'b1;
                ev.kind  = KIND_AXIS;
                ev.code  = CODE_Z;
                ev.value = sext_delta(d.delta_b);
            end
            SLOT_PS_B:
            begin
                ev.port = 1'b1;
            end
            default:
            begin
                ev.port = rport;
                case (off)
                    OFF_UP:
                    begin
                        ev.kind  = KIND_AXIS;
                        ev.code  = CODE_Y;
                        ev.value = k[KEY_UP] ? '0 : AXIS_NEG;
                    end
                    OFF_LEFT:
                    begin
                        ev.kind  = KIND_AXIS;
                        ev.code  = CODE_X;
                        ev.value = k[KEY_LEFT] ? '0 : AXIS_NEG;
                    end
                    OFF_DOWN:
                    begin
                        ev.kind  = KIND_AXIS;
                        ev.code  = CODE_Y;
                        ev.value = k[KEY_DOWN] ? '0 : AXIS_POS;
                    end
                    OFF_RIGHT:
                    begin
                        ev.kind  = KIND_AXIS;
                        ev.code  = CODE_X;
                        ev.value = k[KEY_RIGHT] ? '0 : AXIS_POS;
                    end
                    OFF_FIRE:
                    begin
                        ev.kind  = KIND_BUTTON;
                        ev.code  = CODE_FIRE;
                        ev.value = k[KEY_FIRE] ? '0 : VALUE_W'(1);
                    end
                    default:
                    begin
                        ev.kind = KIND_SYNC;
                    end
                endcase
            end
        endcase
        return ev;
    endfunction

endpackage

### src/jcee_front.sv
// front end: keeps previous key and paddle values and classifies each frame into an event mask
module jcee_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              read_ok,
    input  logic [7:0]        left_keys,
    input  logic [7:0]        right_keys,
    input  logic [7:0]        paddle_a,
    input  logic [7:0]        paddle_b,
    output logic              q_push,
    output jcee_pkg::desc_t   q_data
);

    logic [7:0] prev_left_reg, prev_left_next;
    logic [7:0] prev_right_reg, prev_right_next;
    logic [7:0] prev_pa_reg, prev_pa_next;
    logic [7:0] prev_pb_reg, prev_pb_next;

    logic                                both_pad;
    logic signed [jcee_pkg::DELTA_W-1:0] da, db;
    logic                                emit_a, emit_b;
    logic [7:0]                          ch_l, ch_r;
    logic                                frame;

    assign frame    = take && read_ok;
    assign both_pad = (paddle_a != 8'd0) && (paddle_b != 8'd0);
    assign da       = $signed({1'b0, paddle_a}) - $signed({1'b0, prev_pa_reg});
    assign db       = $signed({1'b0, paddle_b}) - $signed({1'b0, prev_pb_reg});
    // small moves are jitter
    assign emit_a   = both_pad && (prev_pa_reg != 8'd0) && (da > 9'sd1 || da < -9'sd1);
    assign emit_b   = both_pad && (prev_pb_reg != 8'd0) && (db > 9'sd1 || db < -9'sd1);
    assign ch_l     = left_keys ^ prev_left_reg;
    assign ch_r     = right_keys ^ prev_right_reg;

    always_comb
    begin
        q_data            = '0;
        q_data.delta_a    = da;
        q_data.delta_b    = db;
        q_data.left_keys  = left_keys;
        q_data.right_keys = right_keys;
        q_data.mask[jcee_pkg::SLOT_PZ_A] = emit_a;
        q_data.mask[jcee_pkg::SLOT_PS_A] = emit_a;
        q_data.mask[jcee_pkg::SLOT_PZ_B] = emit_b;
        q_data.mask[jcee_pkg::SLOT_PS_B] = emit_b;
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_UP]    = ch_l[jcee_pkg::KEY_UP];
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_LEFT]  = ch_l[jcee_pkg::KEY_LEFT];
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_DOWN]  = ch_l[jcee_pkg::KEY_DOWN];
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_RIGHT] = ch_l[jcee_pkg::KEY_RIGHT];
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_FIRE]  = ch_l[jcee_pkg::KEY_FIRE];
        q_data.mask[jcee_pkg::SLOT_KEY_L + jcee_pkg::OFF_SYNC]  = (ch_l != 8'd0);
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_UP]    = ch_r[jcee_pkg::KEY_UP];
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_LEFT]  = ch_r[jcee_pkg::KEY_LEFT];
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_DOWN]  = ch_r[jcee_pkg::KEY_DOWN];
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_RIGHT] = ch_r[jcee_pkg::KEY_RIGHT];
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_FIRE]  = ch_r[jcee_pkg::KEY_FIRE];
        q_data.mask[jcee_pkg::SLOT_KEY_R + jcee_pkg::OFF_SYNC]  = (ch_r != 8'd0);
    end

    // frames that cause no event never enter the queue
    assign q_push = frame && (q_data.mask != '0);

    always_comb
    begin
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        prev_pa_next    = prev_pa_reg;
        prev_pb_next    = prev_pb_reg;
        if (frame)
        begin
            prev_left_next  = left_keys;
            prev_right_next = right_keys;
            if (both_pad)
            begin
                prev_pa_next = paddle_a;
                prev_pb_next = paddle_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= jcee_pkg::KEYS_RESET;
            prev_right_reg <= jcee_pkg::KEYS_RESET;
            prev_pa_reg    <= 8'd0;
            prev_pb_reg    <= 8'd0;
        end
        else
        begin
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            prev_pa_reg    <= prev_pa_next;
            prev_pb_reg    <= prev_pb_next;
        end
    end

endmodule

### src/jcee_fifo.sv
// short descriptor queue between the front and back ends
module jcee_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jcee_pkg::desc_t   wr_data,
    input  logic              pop,
    output jcee_pkg::desc_t   rd_data,
    output logic              full,
    output logic              empty
);

    jcee_pkg::desc_t                 mem_reg [jcee_pkg::QDEPTH];
    logic [jcee_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [jcee_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [jcee_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == jcee_pkg::QCNT_W'(jcee_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == jcee_pkg::QPTR_W'(jcee_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == jcee_pkg::QPTR_W'(jcee_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/jcee_back.sv
// back end: walks a frame's event mask into the output reg, one per cycle unless stalled
module jcee_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  jcee_pkg::desc_t                  q_data,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic                             port,
    output logic [1:0]                       kind,
    output logic [1:0]                       code,
    output logic signed [jcee_pkg::VALUE_W-1:0] value,
    output logic                             last
);

    jcee_pkg::desc_t               cur_reg, cur_next;
    logic                          out_valid_reg, out_valid_next;
    jcee_pkg::event_t              out_ev_reg, out_ev_next;
    logic                          out_last_reg, out_last_next;

    logic                          advance;
    logic                          busy;
    logic [jcee_pkg::SLOT_W-1:0]   slot;
    logic [jcee_pkg::NUM_SLOTS-1:0] rem;
    logic                          emit;
    jcee_pkg::event_t              ev;

    assign busy    = (cur_reg.mask != '0);
    assign advance = !out_valid_reg || pop;
    assign emit    = busy && advance;
    assign rem     = cur_reg.mask & (cur_reg.mask - 1'b1);
    // load the next frame when idle or when the current one hands out its final event
    assign q_pop   = !q_empty && (!busy || (emit && rem == '0));

    always_comb
    begin
        slot = '0;
        for (int i = jcee_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
            begin
                slot = jcee_pkg::SLOT_W'(i);
            end
        end
    end

    assign ev = jcee_pkg::ev_decode(slot, cur_reg);

    always_comb
    begin
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            cur_next.mask = rem;
            out_ev_next   = ev;
            out_last_next = (rem == '0);
        end
        if (q_pop)
        begin
            cur_next = q_data;
        end
        if (advance)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            out_ev_reg    <= out_ev_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign empty = !out_valid_reg;
    assign port  = out_ev_reg.port;
    assign kind  = out_ev_reg.kind;
    assign code  = out_ev_reg.code;
    assign value = out_ev_reg.value;
    assign last  = out_last_reg;

endmodule

### src/joystick_change_event_encoder_unit.sv
// top level of the joystick change-event encoder
//
//  channel | handshake     | payload
//  --------+---------------+-------------------------------------------------
//  frame   | push / full   | read_ok, left_keys, right_keys, paddle_a, paddle_b
//  event   | empty / pop   | port, kind, code, value, last
//
// a frame is classified in the cycle it is accepted; one accepted frame per cycle
// while the two-entry descriptor queue has room
// a frame with n events (0 to 16) holds the back-end sequencer until all n are handed out,
// one event per cycle while pop does not stall, so the sustained rate is set by the event
// count of each frame; its events go via the queue and frame register to the output register
// reset clears the stored key bytes to 0x2f, the paddles to zero and empties the queue
// a stalled pop only holds the back end; the front keeps taking frames until the queue fills
module joystick_change_event_encoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                read_ok,
    input  logic [7:0]                          left_keys,
    input  logic [7:0]                          right_keys,
    input  logic [7:0]                          paddle_a,
    input  logic [7:0]                          paddle_b,
    output logic                                empty,
    input  logic                                pop,
    output logic                                port,
    output logic [1:0]                          kind,
    output logic [1:0]                          code,
    output logic signed [jcee_pkg::VALUE_W-1:0] value,
    output logic                                last
);

    logic            q_push, q_pop, q_full, q_empty;
    jcee_pkg::desc_t q_wr, q_rd;

    assign full = q_full;

    jcee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (push && !q_full),
        .read_ok    (read_ok),
        .left_keys  (left_keys),
        .right_keys (right_keys),
        .paddle_a   (paddle_a),
        .paddle_b   (paddle_b),
        .q_push     (q_push),
        .q_data     (q_wr)
    );

    jcee_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    jcee_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .port    (port),
        .kind    (kind),
        .code    (code),
        .value   (value),
        .last    (last)
    );

    // every frame's event group closes with a sync
    a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (kind == jcee_pkg::KIND_SYNC))
        else $error("final event of a frame is not a sync");

    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == jcee_pkg::KIND_SYNC) |-> (code == jcee_pkg::CODE_X && value == '0))
        else $error("sync event carries nonzero code or value");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == jcee_pkg::KIND_AXIS && code == jcee_pkg::CODE_Z)
        |-> (value <= 16'sd254 && value >= -16'sd254 && value != 16'sd1
             && value != -16'sd1 && value != 16'sd0))
        else $error("paddle delta out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("descriptor written into a full queue");

endmodule
